### rtl/core/afsp_pkg.sv
package afsp_pkg;

   // field and datapath widths
   localparam int CODE_W      = 16;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 8;
   localparam int FMT_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // product of a signed sample and an unsigned gain, plus one sign bit
   localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
   localparam int DIV_SHIFT   = 3;
   localparam int DIV_ROUND   = (1 << DIV_SHIFT) - 1;
   localparam int QUOT_W      = PROD_W - DIV_SHIFT;

   localparam int SAT_MAX     = 32767;
   localparam int SAT_MIN     = -32768;

   // g.711 decode constants
   localparam logic [SAMPLE_W-1:0] MULAW_BIAS  = 16'h0084;
   localparam logic [SAMPLE_W-1:0] ALAW_SEG0   = 16'h0008;
   localparam logic [SAMPLE_W-1:0] ALAW_BIAS   = 16'h0108;
   localparam logic [7:0]          ALAW_INVERT = 8'h55;
   localparam logic [CODE_W-1:0]   FLIP_BIT15  = 16'h8000;
   localparam logic [CODE_W-1:0]   FLIP_BIT7   = 16'h0080;

   // sample formats; the spare code decodes as signed 8-bit
   typedef enum logic [FMT_W-1:0] {
      FMT_MULAW      = 3'd0,
      FMT_ALAW       = 3'd1,
      FMT_S8         = 3'd2,
      FMT_U8         = 3'd3,
      FMT_S16        = 3'd4,
      FMT_U16_FLIP15 = 3'd5,
      FMT_U16_FLIP7  = 3'd6
   } fmt_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FORMAT = 2'd0,
      CSR_STEREO = 2'd1,
      CSR_GAIN   = 2'd2
   } csr_index_type;

   localparam fmt_type             FORMAT_RESET = FMT_MULAW;
   localparam logic                STEREO_RESET = 1'b0;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd7;

   // input beat
   typedef struct packed {
      logic [CODE_W-1:0] left_code;
      logic [CODE_W-1:0] right_code;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_type;

endpackage

### rtl/core/audio_format_to_stereo_pcm.sv
// an accepted req beat passes the input register, then the output register, before rsp_valid
// throughput: one beat per cycle while rsp_stall is low; decode, one 16x9 multiply per lane
// and the divide by eight and clamp sit between the input and output registers
// req_stall rises only when both registers are full and rsp_stall is high
// reset (synchronous, active high) empties the pipeline and sets format mu-law,
// mono mode and gain 7
module audio_format_to_stereo_pcm (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  afsp_pkg::req_type                   req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output afsp_pkg::rsp_type                   rsp_data,

   input  logic                                csr_write_en,
   input  logic [afsp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   afsp_pkg::fmt_type                 format_ff, format_in;
   logic                              stereo_ff, stereo_in;
   logic [afsp_pkg::GAIN_W-1:0]       gain_ff, gain_in;

   // pipeline registers
   logic                              s1_valid_ff, s1_valid_in;
   afsp_pkg::req_type                 s1_data_ff, s1_data_in;
   logic                              out_valid_ff, out_valid_in;
   afsp_pkg::rsp_type                 out_data_ff, out_data_in;

   logic                              s1_move;
   logic                              out_move;

   logic [afsp_pkg::CODE_W-1:0]       right_sel;
   logic signed [afsp_pkg::SAMPLE_W-1:0] dec_left;
   logic signed [afsp_pkg::SAMPLE_W-1:0] dec_right;
   logic signed [afsp_pkg::PROD_W-1:0]   gain_s;
   logic signed [afsp_pkg::PROD_W-1:0]   prod_left;
   logic signed [afsp_pkg::PROD_W-1:0]   prod_right;
   logic signed [afsp_pkg::SAMPLE_W-1:0] sat_left;
   logic signed [afsp_pkg::SAMPLE_W-1:0] sat_right;

   // register writes
   always_comb begin
      format_in = format_ff;
      stereo_in = stereo_ff;
      gain_in   = gain_ff;
      if (csr_write_en) begin
         unique case (afsp_pkg::csr_index_type'(csr_index))
            afsp_pkg::CSR_FORMAT: format_in = afsp_pkg::fmt_type'(csr_wdata[afsp_pkg::FMT_W-1:0]);
            afsp_pkg::CSR_STEREO: stereo_in = csr_wdata[0];
            afsp_pkg::CSR_GAIN:   gain_in   = csr_wdata[afsp_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= afsp_pkg::FORMAT_RESET;
         stereo_ff <= afsp_pkg::STEREO_RESET;
         gain_ff   <= afsp_pkg::GAIN_RESET;
      end else begin
         format_ff <= format_in;
         stereo_ff <= stereo_in;
         gain_ff   <= gain_in;
      end
   end

   // stage advance: a stage loads when it is empty or its beat moves on
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || out_move;
   assign req_stall = !s1_move;

   // mono mode runs the left code through the right lane too
   assign right_sel = stereo_ff ? s1_data_ff.right_code : s1_data_ff.left_code;

   afsp_decode u_dec_left (
      .fmt    (format_ff),
      .code   (s1_data_ff.left_code),
      .sample (dec_left)
   );

   afsp_decode u_dec_right (
      .fmt    (format_ff),
      .code   (right_sel),
      .sample (dec_right)
   );

   // gain multiply
   assign gain_s = afsp_pkg::PROD_W'(signed'({1'b0, gain_ff}));

   always_comb begin
      prod_left  = afsp_pkg::PROD_W'(dec_left) * gain_s;
      prod_right = afsp_pkg::PROD_W'(dec_right) * gain_s;
   end

   afsp_saturate u_sat_left (
      .prod   (prod_left),
      .sample (sat_left)
   );

   afsp_saturate u_sat_right (
      .prod   (prod_right),
      .sample (sat_right)
   );

   // next state of the stage valids and payloads
   always_comb begin
      s1_valid_in  = s1_move ? req_valid : s1_valid_ff;
      s1_data_in   = req_data;
      out_valid_in = out_move ? s1_valid_ff : out_valid_ff;
      out_data_in.left_out  = sat_left;
      out_data_in.right_out = sat_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_data_ff <= s1_data_in;
      end
      if (out_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

   // an accepted beat lands in the input stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted beat lost at input stage");

   // a blocked input stage keeps its beat
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_move) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input stage dropped a blocked beat");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

### rtl/core/afsp_decode.sv
module afsp_decode (
   input  afsp_pkg::fmt_type                    fmt,
   input  logic [afsp_pkg::CODE_W-1:0]          code,
   output logic signed [afsp_pkg::SAMPLE_W-1:0] sample
);

   logic [7:0]                    ulaw_u;
   logic [afsp_pkg::SAMPLE_W-1:0] ulaw_t;
   logic [afsp_pkg::SAMPLE_W-1:0] ulaw_val;
   logic [7:0]                    alaw_a;
   logic [2:0]                    alaw_seg;
   logic [afsp_pkg::SAMPLE_W-1:0] alaw_base;
   logic [afsp_pkg::SAMPLE_W-1:0] alaw_t;
   logic [afsp_pkg::SAMPLE_W-1:0] alaw_val;
   logic [afsp_pkg::SAMPLE_W-1:0] raw;

   // mu-law: biased mantissa shifted by segment, bias removed
   always_comb begin
      ulaw_u   = ~code[7:0];
      ulaw_t   = (afsp_pkg::SAMPLE_W'({ulaw_u[3:0], 3'b000}) + afsp_pkg::MULAW_BIAS)
                 << ulaw_u[6:4];
      ulaw_val = ulaw_u[7] ? (afsp_pkg::MULAW_BIAS - ulaw_t)
                           : (ulaw_t - afsp_pkg::MULAW_BIAS);
   end

   // a-law: segment zero is linear, others carry the implicit leading one
   always_comb begin
      alaw_a    = code[7:0] ^ afsp_pkg::ALAW_INVERT;
      alaw_seg  = alaw_a[6:4];
      alaw_base = afsp_pkg::SAMPLE_W'({alaw_a[3:0], 4'b0000});
      if (alaw_seg == 3'd0) begin
         alaw_t = alaw_base + afsp_pkg::ALAW_SEG0;
      end else begin
         alaw_t = (alaw_base + afsp_pkg::ALAW_BIAS) << (alaw_seg - 3'd1);
      end
      alaw_val = alaw_a[7] ? alaw_t : (afsp_pkg::SAMPLE_W'(0) - alaw_t);
   end

   // format select
   always_comb begin
      unique case (fmt)
         afsp_pkg::FMT_MULAW:      raw = ulaw_val;
         afsp_pkg::FMT_ALAW:       raw = alaw_val;
         afsp_pkg::FMT_U8:         raw = {~code[7], code[6:0], 8'h00};
         afsp_pkg::FMT_S16:        raw = code;
         afsp_pkg::FMT_U16_FLIP15: raw = code ^ afsp_pkg::FLIP_BIT15;
         afsp_pkg::FMT_U16_FLIP7:  raw = code ^ afsp_pkg::FLIP_BIT7;
         default:                  raw = {code[7:0], 8'h00};
      endcase
   end

   assign sample = signed'(raw);

endmodule

### rtl/core/afsp_saturate.sv
module afsp_saturate (
   input  logic signed [afsp_pkg::PROD_W-1:0]   prod,
   output logic signed [afsp_pkg::SAMPLE_W-1:0] sample
);

   logic signed [afsp_pkg::PROD_W-1:0] biased;
   logic signed [afsp_pkg::QUOT_W-1:0] quot;

   // divide by eight, truncating toward zero
   always_comb begin
      if (prod[afsp_pkg::PROD_W-1]) begin
         biased = prod + afsp_pkg::PROD_W'(afsp_pkg::DIV_ROUND);
      end else begin
         biased = prod;
      end
      quot = biased[afsp_pkg::PROD_W-1:afsp_pkg::DIV_SHIFT];
   end

   // clamp to the signed 16-bit range
   always_comb begin
      priority if (quot > afsp_pkg::QUOT_W'(afsp_pkg::SAT_MAX)) begin
         sample = afsp_pkg::SAMPLE_W'(afsp_pkg::SAT_MAX);
      end else if (quot < afsp_pkg::QUOT_W'(afsp_pkg::SAT_MIN)) begin
         sample = afsp_pkg::SAMPLE_W'(afsp_pkg::SAT_MIN);
      end else begin
         sample = afsp_pkg::SAMPLE_W'(quot);
      end
   end

endmodule
